// ===== hdl/multichannel_frame_ring_buffer_macros.svh =====
// assertion macros for the multichannel frame ring buffer
`ifndef MULTICHANNEL_FRAME_RING_BUFFER_MACROS_SVH
`define MULTICHANNEL_FRAME_RING_BUFFER_MACROS_SVH

// condition holds at every edge out of reset
`define FRB_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FRB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds after the antecedent, not in its cycle
`define FRB_ASSERT_DELAY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) else $error(msg);

`endif

// ===== hdl/frb_pkg.sv =====
// shared types, codes and constants of the multichannel frame ring buffer
package frb_pkg;

  localparam int NUM_LANES     = 8;
  localparam int LANE_BITS     = 32;
  localparam int CNT_W         = 11;
  localparam int CH_W          = 4;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 11;
  localparam int DEF_DEPTH     = 1024;
  localparam int DEF_CHANNELS  = 8;
  localparam int DEF_SAMPLE_W  = 32;
  localparam logic [CNT_W-1:0] RST_CAPACITY = 11'd1024;
  localparam logic [CH_W-1:0]  RST_CHANNELS = 4'd2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_CAPACITY = 1'b0,
    CFG_CHANNEL_COUNT  = 1'b1
  } cfg_reg_t;

  typedef logic [NUM_LANES-1:0][LANE_BITS-1:0] lanes_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [LANE_BITS-1:0] sample_0;
    logic [LANE_BITS-1:0] sample_1;
    logic [LANE_BITS-1:0] sample_2;
    logic [LANE_BITS-1:0] sample_3;
    logic [LANE_BITS-1:0] sample_4;
    logic [LANE_BITS-1:0] sample_5;
    logic [LANE_BITS-1:0] sample_6;
    logic [LANE_BITS-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [LANE_BITS-1:0] out_sample_0;
    logic [LANE_BITS-1:0] out_sample_1;
    logic [LANE_BITS-1:0] out_sample_2;
    logic [LANE_BITS-1:0] out_sample_3;
    logic [LANE_BITS-1:0] out_sample_4;
    logic [LANE_BITS-1:0] out_sample_5;
    logic [LANE_BITS-1:0] out_sample_6;
    logic [LANE_BITS-1:0] out_sample_7;
    logic                 accepted;
    logic [CNT_W-1:0]     frames_held;
    logic [CNT_W-1:0]     frames_free;
  } out_item_t;

  // result bookkeeping carried alongside the memory read
  typedef struct packed {
    logic                 accepted;
    logic [NUM_LANES-1:0] lane_en;
    logic [CNT_W-1:0]     readable;
    logic [CNT_W-1:0]     writable;
  } meta_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap_eff;
  } status_t;

  function automatic lanes_t in_lanes(input in_item_t item);
    lanes_t l;
    l[0] = item.sample_0;
    l[1] = item.sample_1;
    l[2] = item.sample_2;
    l[3] = item.sample_3;
    l[4] = item.sample_4;
    l[5] = item.sample_5;
    l[6] = item.sample_6;
    l[7] = item.sample_7;
    return l;
  endfunction

  function automatic out_item_t pack_out(input lanes_t l, input meta_t m);
    out_item_t o;
    o.out_sample_0 = l[0];
    o.out_sample_1 = l[1];
    o.out_sample_2 = l[2];
    o.out_sample_3 = l[3];
    o.out_sample_4 = l[4];
    o.out_sample_5 = l[5];
    o.out_sample_6 = l[6];
    o.out_sample_7 = l[7];
    o.accepted     = m.accepted;
    o.frames_held  = m.readable;
    o.frames_free  = m.writable;
    return o;
  endfunction

endpackage

// ===== hdl/frb_store.sv =====
// per-lane sample memories with registered read
module frb_store #(
  parameter int DEPTH_FRAMES = frb_pkg::DEF_DEPTH,
  parameter int MAX_CHANNELS = frb_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS  = frb_pkg::DEF_SAMPLE_W,
  localparam int IDX_W       = $clog2(DEPTH_FRAMES)
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [MAX_CHANNELS-1:0]                   wr_lane_en,
  input  logic [IDX_W-1:0]                          wr_addr,
  input  frb_pkg::in_item_t                         wr_item,
  input  logic                                      rd_en,
  input  logic [IDX_W-1:0]                          rd_addr,
  output logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0]  rd_data_r
);
  import frb_pkg::*;

  lanes_t wr_lanes;

  assign wr_lanes = in_lanes(wr_item);

  for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
    logic [SAMPLE_BITS-1:0] mem [DEPTH_FRAMES];

    always_ff @(posedge clk) begin
      if (wr_en && wr_lane_en[l]) begin
        mem[wr_addr] <= SAMPLE_BITS'(wr_lanes[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_data_r[l] <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== hdl/frb_ctrl.sv =====
// configuration registers, ring indices, frame count and per-item decision
module frb_ctrl #(
  parameter int DEPTH_FRAMES = frb_pkg::DEF_DEPTH,
  parameter int MAX_CHANNELS = frb_pkg::DEF_CHANNELS,
  localparam int IDX_W       = $clog2(DEPTH_FRAMES)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  frb_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [frb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [frb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                wr_en,
  output logic [MAX_CHANNELS-1:0]             wr_lane_en,
  output logic [IDX_W-1:0]                    wr_addr,
  output logic                                rd_en,
  output logic [IDX_W-1:0]                    rd_addr,
  output logic                                vld_r,
  output frb_pkg::meta_t                      meta_r,
  output frb_pkg::status_t                    status
);
  import frb_pkg::*;

  localparam int CMP_W = 17;

  logic [CNT_W-1:0] cap_r;
  logic [CH_W-1:0]  ch_r;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic [CH_W-1:0]  ch_eff;
  logic [NUM_LANES-1:0] lane_en;
  logic [CMP_W-1:0] cap_ext, rd_ext, wr_ext, rd_inc, wr_inc;
  logic             push_ok, pop_ok, ok;
  meta_t            meta_nxt;

  always_comb begin
    if (32'(cap_r) > 32'(DEPTH_FRAMES)) begin
      cap_eff = CNT_W'(DEPTH_FRAMES);
    end else begin
      cap_eff = cap_r;
    end
    if (ch_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (32'(ch_r) > 32'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = ch_r;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_en[l] = CH_W'(l) < ch_eff;
    end
  end

  assign cap_ext = CMP_W'(cap_eff);
  assign rd_ext  = CMP_W'(rd_idx_r);
  assign wr_ext  = CMP_W'(wr_idx_r);
  assign rd_inc  = rd_ext + CMP_W'(1);
  assign wr_inc  = wr_ext + CMP_W'(1);

  always_comb begin
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    ok         = 1'b0;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    count_nxt  = count_r;
    if (accept) begin
      unique case (in_item.operation)
        OP_PUSH: begin
          if (cap_eff != '0 && count_r < cap_eff && wr_ext < cap_ext) begin
            push_ok    = 1'b1;
            ok         = 1'b1;
            wr_idx_nxt = (wr_inc >= cap_ext) ? '0 : IDX_W'(wr_inc);
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (cap_eff != '0 && count_r != '0 && rd_ext < cap_ext) begin
            pop_ok     = 1'b1;
            ok         = 1'b1;
            rd_idx_nxt = (rd_inc >= cap_ext) ? '0 : IDX_W'(rd_inc);
            count_nxt  = count_r - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          ok         = 1'b1;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          count_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
    // a register write also empties the buffer
    if (cfg_we) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_comb begin
    meta_nxt.accepted = ok;
    meta_nxt.lane_en  = pop_ok ? lane_en : '0;
    meta_nxt.readable = count_nxt;
    meta_nxt.writable = (count_nxt <= cap_eff) ? cap_eff - count_nxt : '0;
  end

  assign wr_en      = push_ok;
  assign wr_lane_en = lane_en[MAX_CHANNELS-1:0];
  assign wr_addr    = wr_idx_r;
  assign rd_en      = pop_ok;
  assign rd_addr    = rd_idx_r;

  assign status.count   = count_r;
  assign status.cap_eff = cap_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= RST_CAPACITY;
      ch_r     <= RST_CHANNELS;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      count_r  <= '0;
      vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_CAPACITY: cap_r <= cfg_wdata[CNT_W-1:0];
          CFG_CHANNEL_COUNT:  ch_r  <= cfg_wdata[CH_W-1:0];
          default: begin
          end
        endcase
      end
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      count_r  <= count_nxt;
      vld_r    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

endmodule

// ===== hdl/multichannel_frame_ring_buffer.sv =====
// top level of the multichannel frame ring buffer
// a result strobes out_valid once its item is accepted, registered through vld_r and then out_valid_r
// throughput: one item per cycle while busy is low, set by the single read and write port per lane memory
// reset: busy is high while rst_n is low and falls at the next edge after it; buffer empty, capacity 1024,
// two channels; sample memory contents are left as they are
module multichannel_frame_ring_buffer #(
  parameter int DEPTH_FRAMES = frb_pkg::DEF_DEPTH,
  parameter int MAX_CHANNELS = frb_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS  = frb_pkg::DEF_SAMPLE_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  frb_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  output frb_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [frb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import frb_pkg::*;

`include "multichannel_frame_ring_buffer_macros.svh"

  localparam int IDX_W = $clog2(DEPTH_FRAMES);

  logic                                     busy_r;
  logic                                     accept;
  logic                                     wr_en, rd_en;
  logic [MAX_CHANNELS-1:0]                  wr_lane_en;
  logic [IDX_W-1:0]                         wr_addr, rd_addr;
  logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] rd_data_r;
  logic                                     vld_r;
  meta_t                                    meta_r;
  status_t                                  status;
  lanes_t                                   out_lanes;
  out_item_t                                out_item_r, out_item_nxt;
  logic                                     out_valid_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  frb_ctrl #(
    .DEPTH_FRAMES (DEPTH_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .wr_en      (wr_en),
    .wr_lane_en (wr_lane_en),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .vld_r      (vld_r),
    .meta_r     (meta_r),
    .status     (status)
  );

  frb_store #(
    .DEPTH_FRAMES (DEPTH_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_lane_en (wr_lane_en),
    .wr_addr    (wr_addr),
    .wr_item    (in_item),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data_r  (rd_data_r)
  );

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
    if (l < MAX_CHANNELS) begin : g_used
      assign out_lanes[l] = meta_r.lane_en[l] ? LANE_BITS'(rd_data_r[l]) : '0;
    end else begin : g_unused
      assign out_lanes[l] = '0;
    end
  end

  assign out_item_nxt = pack_out(out_lanes, meta_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `FRB_ASSERT_DELAY2(a_item_to_result, accept, out_valid, "accepted item gave no result")
  `FRB_ASSERT_DELAY2(a_no_spurious_result, !accept, !out_valid, "result without an item")
  `FRB_ASSERT_ALWAYS(a_count_in_capacity, status.count <= status.cap_eff, "frame count above capacity")
  `FRB_ASSERT_IMPLY(a_refused_no_samples, out_valid && !out_item.accepted, out_item.out_sample_0 == '0 && out_item.out_sample_7 == '0, "refused item returned samples")

endmodule

// ===== bench/multichannel_frame_ring_buffer_tb.sv =====
// testbench for the multichannel frame ring buffer: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module multichannel_frame_ring_buffer_tb;
  import frb_pkg::*;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;
  localparam logic KIND_ITEM = 1'b0;
  localparam logic KIND_CFG  = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam logic TYPED     = 1'b1;
  localparam int DIR_ROWS    = 34;
  localparam int SLOTS       = 1024;

  typedef struct packed {
    logic             kind;
    cfg_reg_t         addr;
    logic [10:0]      data;
    logic [1:0]       op;
    logic [31:0]      pat;
    logic             typed;
    logic             acc;
    logic [CNT_W-1:0] rd;
    logic [CNT_W-1:0] wr;
  } step_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [31:0]      frame_mem [0:SLOTS-1][0:7];
  int               rd_ptr, wr_ptr, held;
  logic [CNT_W-1:0] cap_reg;
  logic [CH_W-1:0]  ch_reg;

  out_item_t frame_results_due [$];
  int        mismatch_cnt = 0;

  step_row_t dir_tab [DIR_ROWS] = '{
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, TYPED,     1'b0, 11'd0, 11'd1024},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_UNDEFINED, 32'h00000000, TYPED,     1'b0, 11'd0, 11'd1024},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'hFFFFFFFF, TYPED,     1'b1, 11'd1, 11'd1023},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h00000000, TYPED,     1'b1, 11'd2, 11'd1022},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_CLEAR,     32'h00000000, TYPED,     1'b1, 11'd0, 11'd1024},
    '{KIND_CFG,  CFG_FRAME_CAPACITY, 11'd2,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_CFG,  CFG_CHANNEL_COUNT,  11'd8,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'hA5A5A5A5, TYPED,     1'b1, 11'd1, 11'd1},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h3C96F00F, TYPED,     1'b1, 11'd2, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h12345678, TYPED,     1'b0, 11'd2, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h89ABCDEF, TYPED,     1'b1, 11'd2, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, TYPED,     1'b0, 11'd0, 11'd2},
    '{KIND_CFG,  CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h55AA33CC, TYPED,     1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, TYPED,     1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_CLEAR,     32'h00000000, TYPED,     1'b1, 11'd0, 11'd0},
    '{KIND_CFG,  CFG_FRAME_CAPACITY, 11'd2047, OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_CFG,  CFG_CHANNEL_COUNT,  11'd0,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'hFFFFFFFF, TYPED,     1'b1, 11'd1, 11'd1023},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_CFG,  CFG_CHANNEL_COUNT,  11'd15,   OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h5A5AC3C3, TYPED,     1'b1, 11'd1, 11'd1023},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_CFG,  CFG_FRAME_CAPACITY, 11'd1,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_CFG,  CFG_CHANNEL_COUNT,  11'd3,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'hC001D00D, TYPED,     1'b1, 11'd1, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_PUSH,      32'h0F0F0F0F, TYPED,     1'b0, 11'd1, 11'd0},
    '{KIND_CFG,  CFG_CHANNEL_COUNT,  11'd4,    OP_PUSH,      32'h00000000, PREDICTED, 1'b0, 11'd0, 11'd0},
    '{KIND_ITEM, CFG_FRAME_CAPACITY, 11'd0,    OP_POP,       32'h00000000, TYPED,     1'b0, 11'd0, 11'd1}
  };

  multichannel_frame_ring_buffer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic out_item_t predict_frame(input in_item_t it);
    logic [31:0] lane_in [8];
    logic [31:0] lane_out [8];
    int          cap, ch;
    logic        ok;
    lane_in[0] = it.sample_0;
    lane_in[1] = it.sample_1;
    lane_in[2] = it.sample_2;
    lane_in[3] = it.sample_3;
    lane_in[4] = it.sample_4;
    lane_in[5] = it.sample_5;
    lane_in[6] = it.sample_6;
    lane_in[7] = it.sample_7;
    cap = (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
    ch  = (ch_reg == 0) ? 1 : (ch_reg > 8) ? 8 : int'(ch_reg);
    ok  = 1'b0;
    for (int c = 0; c < 8; c++) lane_out[c] = '0;
    case (it.operation)
      OP_PUSH: begin
        if (cap != 0 && held < cap) begin
          for (int c = 0; c < ch; c++) frame_mem[wr_ptr][c] = lane_in[c];
          wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
          held++;
          ok = 1'b1;
        end
      end
      OP_POP: begin
        if (cap != 0 && held != 0) begin
          for (int c = 0; c < ch; c++) lane_out[c] = frame_mem[rd_ptr][c];
          rd_ptr = (rd_ptr + 1 >= cap) ? 0 : rd_ptr + 1;
          held--;
          ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
        held   = 0;
        ok     = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    return {lane_out[0], lane_out[1], lane_out[2], lane_out[3], lane_out[4], lane_out[5],
            lane_out[6], lane_out[7], ok, CNT_W'(held), CNT_W'(cap - held)};
  endfunction

  function automatic in_item_t random_frame(input int push_pct);
    in_item_t it;
    int       r;
    r = $urandom_range(999);
    if (r < 20) it.operation = OP_CLEAR;
    else if (r < 35) it.operation = OP_UNDEFINED;
    else if ($urandom_range(99) < push_pct) it.operation = OP_PUSH;
    else it.operation = OP_POP;
    it.sample_0 = $urandom();
    it.sample_1 = $urandom();
    it.sample_2 = $urandom();
    it.sample_3 = $urandom();
    it.sample_4 = $urandom();
    it.sample_5 = $urandom();
    it.sample_6 = $urandom();
    it.sample_7 = $urandom();
    return it;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_item(input in_item_t it, input logic typed, input out_item_t typed_res,
                            input int gap);
    out_item_t pred;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = predict_frame(it);
    frame_results_due.push_back(typed ? typed_res : pred);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // only while idle; any register write also empties the buffer
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_CAPACITY) cap_reg = val;
    else ch_reg = val[CH_W-1:0];
    rd_ptr = 0;
    wr_ptr = 0;
    held   = 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        mismatch_cnt++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("out_sample_0", want.out_sample_0, out_item.out_sample_0);
        check_field("out_sample_1", want.out_sample_1, out_item.out_sample_1);
        check_field("out_sample_2", want.out_sample_2, out_item.out_sample_2);
        check_field("out_sample_3", want.out_sample_3, out_item.out_sample_3);
        check_field("out_sample_4", want.out_sample_4, out_item.out_sample_4);
        check_field("out_sample_5", want.out_sample_5, out_item.out_sample_5);
        check_field("out_sample_6", want.out_sample_6, out_item.out_sample_6);
        check_field("out_sample_7", want.out_sample_7, out_item.out_sample_7);
        check_field("accepted", 32'(want.accepted), 32'(out_item.accepted));
        check_field("frames_held", 32'(want.frames_held), 32'(out_item.frames_held));
        check_field("frames_free", 32'(want.frames_free), 32'(out_item.frames_free));
      end
    end
  end

  initial begin
    step_row_t        row;
    in_item_t         it;
    logic [31:0]      l [8];
    logic [63:0]      wide;
    out_item_t        typed_res;
    logic [10:0]      cap_val;
    int               n, push_pct, sel;
    bit               quiet;

    cap_reg = RST_CAPACITY;
    ch_reg  = RST_CHANNELS;
    rd_ptr  = 0;
    wr_ptr  = 0;
    held    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.kind == KIND_CFG) begin
        write_reg(row.addr, row.data);
      end else begin
        for (int c = 0; c < 8; c++) begin
          wide = {row.pat, row.pat} >> (32 - 4 * c);
          l[c] = wide[31:0];
        end
        it = {row.op, l[0], l[1], l[2], l[3], l[4], l[5], l[6], l[7]};
        typed_res = {256'b0, row.acc, row.rd, row.wr};
        issue_item(it, row.typed, typed_res, pick_gap(1'b0));
      end
    end

    // random phases over mostly small geometries
    for (int p = 0; p < 10; p++) begin
      sel = $urandom_range(7);
      case (sel)
        0: cap_val = 11'd0;
        1: cap_val = 11'd1;
        2, 3: cap_val = 11'($urandom_range(2, 6));
        4: cap_val = 11'($urandom_range(7, 40));
        5: cap_val = 11'd2047;
        6: cap_val = 11'($urandom_range(1025, 2046));
        default: cap_val = 11'($urandom_range(41, 1024));
      endcase
      write_reg(CFG_FRAME_CAPACITY, cap_val);
      write_reg(CFG_CHANNEL_COUNT, 11'($urandom_range(2047)));
      push_pct = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 30 : 50;
      quiet = (p % 3 == 2);
      n = $urandom_range(10, 14);
      for (int k = 0; k < n; k++) issue_item(random_frame(push_pct), PREDICTED, '0, pick_gap(quiet));
    end

    // full depth: fill past capacity, then mixed traffic with wrap
    write_reg(CFG_FRAME_CAPACITY, 11'd1024);
    write_reg(CFG_CHANNEL_COUNT, 11'($urandom_range(1, 8)));
    for (int k = 0; k < SLOTS + 3; k++) begin
      it = random_frame(100);
      it.operation = OP_PUSH;
      issue_item(it, PREDICTED, '0, pick_gap(k % 256 < 128));
    end
    for (int k = 0; k < 40; k++) issue_item(random_frame(50), PREDICTED, '0, pick_gap(1'b0));

    start <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
